// ===== hdl/oaht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package oaht_pkg;

    // default number of slots in the store
    localparam int CAPACITY_DEF = 1024;

    // field widths
    localparam int KEY_W    = 31;
    localparam int SIZE_W   = 11;
    localparam int SLOT_W   = 10;
    localparam int PROBE_W  = 11;

    // (13*key+1)/2 fits in this many bits
    localparam int HASH_W    = KEY_W + 3;
    localparam int DIV_STEPS = HASH_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // register map
    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-1:0] REG_PROBING_MODE = 3'd0;
    localparam logic [ADDR_W-1:0] REG_TABLE_SIZE   = 3'd4;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 11'd101;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_SEARCH = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_INS_FAIL = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISSING  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_READ,
        S_CHECK,
        S_FINISH
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/open_addressing_hash_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Open-addressing hash table of nonzero 31-bit keys held in one single-port synchronous
// memory of CAPACITY slots (zero marks an empty slot). After reset a clearing pass writes
// every slot to zero, during which no transaction is accepted. Each operation is accepted,
// then (13*key+1)/2 is reduced modulo the table size (a two-bits-per-cycle remainder
// unit), then each probe reads memory and then compares and writes, and finally the
// result is handed to the output register once it is free. One operation is in flight at
// a time; zero keys and linear inserts into a full table finish without touching memory.
// probing_mode and table_size are written over APB at byte addresses 0 and 4 and may only
// be changed while the block is idle.
module open_addressing_hash_table #(
    parameter int CAPACITY = oaht_pkg::CAPACITY_DEF
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    // apb configuration
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [oaht_pkg::ADDR_W-1:0]       paddr,
    input  wire  [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // request channel
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire                               s_action,
    input  wire  [oaht_pkg::KEY_W-1:0]        s_key,
    // result channel
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [1:0]                        m_status,
    output logic [oaht_pkg::SLOT_W-1:0]       m_slot,
    output logic [oaht_pkg::PROBE_W-1:0]      m_probe_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int SW = $clog2(CAPACITY + 1);
    localparam int CW = (SW > oaht_pkg::SIZE_W) ? SW : oaht_pkg::SIZE_W;
    localparam int KW = oaht_pkg::KEY_W;
    localparam int HW = oaht_pkg::HASH_W;
    localparam int NW = oaht_pkg::DIV_CNT_W;

    oaht_pkg::state_t state_reg, state_next;

    // configuration registers
    logic                        mode_reg;
    logic [oaht_pkg::SIZE_W-1:0] size_reg;

    // operation registers
    logic          action_reg, action_next;
    logic [KW-1:0] key_reg, key_next;
    logic [HW-1:0] hash_reg, hash_next;
    logic [SW:0]   rem_reg, rem_next;
    logic [NW-1:0] div_cnt_reg, div_cnt_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [SW-1:0] delta_reg, delta_next;
    logic [SW:0]   pc_reg, pc_next;
    logic [SW-1:0] occ_reg, occ_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    // pending result
    logic [1:0]    res_status_reg, res_status_next;
    logic [AW-1:0] res_slot_reg, res_slot_next;
    logic [SW:0]   res_probes_reg, res_probes_next;

    // output register
    logic                         m_valid_reg, m_valid_next;
    logic [1:0]                   m_status_reg, m_status_next;
    logic [oaht_pkg::SLOT_W-1:0]  m_slot_reg, m_slot_next;
    logic [oaht_pkg::PROBE_W-1:0] m_probes_reg, m_probes_next;

    // memory port
    logic [KW-1:0] mem [CAPACITY];
    logic [KW-1:0] rd_data_reg;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [KW-1:0] mem_wdata;

    // combinational helpers
    logic [CW-1:0] size_ext;
    logic [SW-1:0] s_eff;
    logic [SW:0]   limit;
    logic [HW-1:0] hash_in;
    logic [SW:0]   rem_a, rem_b;
    logic [SW:0]   idx_sum, idx_wrap;
    logic [SW:0]   dl_sum, dl_wrap;
    logic          hit;
    logic          cfg_wr;

    // effective table size, saturated to 2..CAPACITY
    always_comb begin
        size_ext = CW'(size_reg);
        if (size_ext < CW'(2)) begin
            s_eff = SW'(2);
        end else if (size_ext > CW'(CAPACITY)) begin
            s_eff = SW'(CAPACITY);
        end else begin
            s_eff = SW'(size_ext);
        end
    end

    // probe limit: linear insert stops after s probes, everything else after s+1
    assign limit = (!mode_reg && action_reg == oaht_pkg::ACT_INSERT)
                   ? {1'b0, s_eff} : ({1'b0, s_eff} + (SW+1)'(1));

    // (13*key+1)/2
    assign hash_in = HW'(((HW+1)'(s_key) * (HW+1)'(13) + (HW+1)'(1)) >> 1);

    // two restoring remainder steps per cycle
    always_comb begin
        rem_a = {rem_reg[SW-1:0], hash_reg[HW-1]};
        if (rem_a >= {1'b0, s_eff}) begin
            rem_a = rem_a - {1'b0, s_eff};
        end
        rem_b = {rem_a[SW-1:0], hash_reg[HW-2]};
        if (rem_b >= {1'b0, s_eff}) begin
            rem_b = rem_b - {1'b0, s_eff};
        end
    end

    // next probe slot and next step, both kept below s
    always_comb begin
        idx_sum  = (SW+1)'(idx_reg) + (SW+1)'(delta_reg);
        idx_wrap = (idx_sum >= {1'b0, s_eff}) ? idx_sum - {1'b0, s_eff} : idx_sum;
        dl_sum   = (SW+1)'(delta_reg) + (SW+1)'(2);
        dl_wrap  = (dl_sum >= {1'b0, s_eff}) ? dl_sum - {1'b0, s_eff} : dl_sum;
    end

    // slot compare for the current probe
    assign hit = (action_reg == oaht_pkg::ACT_INSERT) ? (rd_data_reg == '0)
                                                       : (rd_data_reg == key_reg);

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= oaht_pkg::S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state, datapath and memory control
    always_comb begin
        state_next      = state_reg;
        action_next     = action_reg;
        key_next        = key_reg;
        hash_next       = hash_reg;
        rem_next        = rem_reg;
        div_cnt_next    = div_cnt_reg;
        idx_next        = idx_reg;
        delta_next      = delta_reg;
        pc_next         = pc_reg;
        occ_next        = occ_reg;
        clr_cnt_next    = clr_cnt_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_probes_next = res_probes_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_slot_next     = m_slot_reg;
        m_probes_next   = m_probes_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_addr        = idx_reg;
        mem_wdata       = key_reg;
        s_ready         = 1'b0;

        unique case (state_reg)
            oaht_pkg::S_CLEAR: begin
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(CAPACITY - 1)) begin
                    state_next = oaht_pkg::S_IDLE;
                end
            end
            oaht_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    action_next     = s_action;
                    key_next        = s_key;
                    hash_next       = hash_in;
                    rem_next        = '0;
                    div_cnt_next    = '0;
                    res_slot_next   = '0;
                    res_probes_next = '0;
                    res_status_next = (s_action == oaht_pkg::ACT_SEARCH)
                                      ? oaht_pkg::ST_MISSING : oaht_pkg::ST_INS_FAIL;
                    if (s_key == '0) begin
                        state_next = oaht_pkg::S_FINISH;
                    end else if (s_action == oaht_pkg::ACT_INSERT && !mode_reg
                                 && occ_reg >= s_eff) begin
                        state_next = oaht_pkg::S_FINISH;
                    end else begin
                        state_next = oaht_pkg::S_DIV;
                    end
                end
            end
            oaht_pkg::S_DIV: begin
                rem_next     = rem_b;
                hash_next    = {hash_reg[HW-3:0], 2'b00};
                div_cnt_next = div_cnt_reg + NW'(1);
                if (div_cnt_reg == NW'(oaht_pkg::DIV_STEPS - 1)) begin
                    idx_next   = AW'(rem_b);
                    delta_next = SW'(1);
                    pc_next    = '0;
                    state_next = oaht_pkg::S_READ;
                end
            end
            oaht_pkg::S_READ: begin
                mem_re     = 1'b1;
                state_next = oaht_pkg::S_CHECK;
            end
            oaht_pkg::S_CHECK: begin
                if (hit) begin
                    if (action_reg == oaht_pkg::ACT_INSERT) begin
                        mem_we          = 1'b1;
                        occ_next        = occ_reg + SW'(1);
                        res_status_next = oaht_pkg::ST_INSERTED;
                    end else begin
                        res_status_next = oaht_pkg::ST_FOUND;
                    end
                    res_slot_next   = idx_reg;
                    res_probes_next = pc_reg;
                    state_next      = oaht_pkg::S_FINISH;
                end else if (pc_reg + (SW+1)'(1) == limit) begin
                    res_probes_next = limit;
                    state_next      = oaht_pkg::S_FINISH;
                end else begin
                    pc_next  = pc_reg + (SW+1)'(1);
                    idx_next = AW'(idx_wrap);
                    if (mode_reg && pc_reg != '0) begin
                        delta_next = SW'(dl_wrap);
                    end
                    state_next = oaht_pkg::S_READ;
                end
            end
            oaht_pkg::S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_slot_next   = oaht_pkg::SLOT_W'(res_slot_reg);
                    m_probes_next = oaht_pkg::PROBE_W'(res_probes_reg);
                    state_next    = oaht_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = oaht_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg     <= '0;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            occ_reg     <= occ_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        action_reg     <= action_next;
        key_reg        <= key_next;
        hash_reg       <= hash_next;
        rem_reg        <= rem_next;
        div_cnt_reg    <= div_cnt_next;
        idx_reg        <= idx_next;
        delta_reg      <= delta_next;
        pc_reg         <= pc_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_probes_reg <= res_probes_next;
        m_status_reg   <= m_status_next;
        m_slot_reg     <= m_slot_next;
        m_probes_reg   <= m_probes_next;
    end

    // slot store, read data registered
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    // apb register file
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            size_reg <= oaht_pkg::TABLE_SIZE_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == oaht_pkg::REG_TABLE_SIZE[2]) begin
                size_reg <= pwdata[oaht_pkg::SIZE_W-1:0];
            end else begin
                mode_reg <= pwdata[0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == oaht_pkg::REG_TABLE_SIZE[2]) begin
            prdata = 32'(size_reg);
        end else begin
            prdata = 32'(mode_reg);
        end
    end

    assign pready        = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_slot        = m_slot_reg;
    assign m_probe_count = m_probes_reg;

endmodule

`default_nettype wire

// ===== hdl/oaht_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module oaht_checker (
    input wire                               aclk,
    input wire                               aresetn,
    input wire                               s_valid,
    input wire                               s_ready,
    input wire                               m_valid,
    input wire                               m_ready,
    input wire [1:0]                         m_status,
    input wire [oaht_pkg::SLOT_W-1:0]        m_slot,
    input wire [oaht_pkg::PROBE_W-1:0]       m_probe_count
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_slot)
                                && $stable(m_probe_count))
        else $error("stalled result changed");

    // failed insert or missed search reports slot zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == oaht_pkg::ST_INS_FAIL || m_status == oaht_pkg::ST_MISSING)
        |-> m_slot == '0)
        else $error("nonzero slot on failure");

    // one operation at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    // reset empties the result channel
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind open_addressing_hash_table oaht_checker u_oaht_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_slot        (m_slot),
    .m_probe_count (m_probe_count)
);

`default_nettype wire
